/* design/esest_pkg.sv */
// esest_pkg: shared types and constants of the encoder speed estimator
// no dependencies; used by the core, the checker and the testbench

package esest_pkg;

  localparam int SEQ_BITS = 16;

  localparam logic [63:0] TWO_PI_Q16 = 64'd411775;
  localparam logic [63:0] SAT_ANGLE  = 64'd4503599627370496;
  localparam logic [63:0] SAT_WIDE   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_NONE   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] US_PER_S   = 64'd1000000;
  localparam logic [63:0] US_PER_MIN = 64'd60000000;
  localparam logic [63:0] Q16_ONE    = 64'd65536;
  localparam logic [63:0] MPS_DIV    = 64'd60000 << 32;

  // configuration register indexes
  localparam logic [1:0] REG_POLARITY = 2'd0;
  localparam logic [1:0] REG_CPR      = 2'd1;
  localparam logic [1:0] REG_GEAR     = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  localparam logic [1:0]  POLARITY_RESET = 2'sd1;
  localparam logic [24:0] CPR_RESET      = 25'd131072;
  localparam logic [31:0] GEAR_RESET     = 32'd65536;
  localparam logic [31:0] RADIUS_RESET   = 32'd3276800;

  typedef enum logic [1:0] {
    STATUS_DUP   = 2'd0,
    STATUS_FIRST = 2'd1,
    STATUS_ZERO  = 2'd2,
    STATUS_VALID = 2'd3
  } status_t;

  // arithmetic steps, in execution order
  localparam int NUM_OPS = 9;
  localparam logic [3:0] OP_CPS  = 4'd0;
  localparam logic [3:0] OP_ANGM = 4'd1;
  localparam logic [3:0] OP_ANGW = 4'd2;
  localparam logic [3:0] OP_X    = 4'd3;
  localparam logic [3:0] OP_Y    = 4'd4;
  localparam logic [3:0] OP_RPMM = 4'd5;
  localparam logic [3:0] OP_RPMW = 4'd6;
  localparam logic [3:0] OP_Z    = 4'd7;
  localparam logic [3:0] OP_MPS  = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_MDONE,
    ST_DIV,
    ST_DDONE,
    ST_OUT
  } state_t;

endpackage

/* design/esest_in_if.sv */
// esest_in_if: encoder sample channel, valid/ready with sample payload
// no dependencies

interface esest_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] counts;
  logic        [31:0] sample_time_us;
  logic        [15:0] sequence_req;

  modport source  (output valid, counts, sample_time_us, sequence_req, input ready);
  modport sink    (input valid, counts, sample_time_us, sequence_req, output ready);
  modport monitor (input valid, ready, counts, sample_time_us, sequence_req);
endinterface

/* design/esest_out_if.sv */
// esest_out_if: speed estimate channel, valid/ready with result payload
// no dependencies

interface esest_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [32:0] count_delta;
  logic        [31:0] interval_us;
  logic signed [51:0] count_rate;
  logic signed [53:0] motor_angle_delta_q16;
  logic signed [53:0] wheel_angle_delta_q16;
  logic signed [63:0] motor_rpm_q16;
  logic signed [63:0] wheel_rpm_q16;
  logic signed [63:0] wheel_mps_q16;
  logic               rate_ok;

  modport source  (output valid, status, count_delta, interval_us, count_rate,
                   motor_angle_delta_q16, wheel_angle_delta_q16, motor_rpm_q16,
                   wheel_rpm_q16, wheel_mps_q16, rate_ok, input ready);
  modport sink    (input valid, status, count_delta, interval_us, count_rate,
                   motor_angle_delta_q16, wheel_angle_delta_q16, motor_rpm_q16,
                   wheel_rpm_q16, wheel_mps_q16, rate_ok, output ready);
  modport monitor (input valid, ready, status, count_delta, interval_us, count_rate,
                   motor_angle_delta_q16, wheel_angle_delta_q16, motor_rpm_q16,
                   wheel_rpm_q16, wheel_mps_q16, rate_ok);
endinterface

/* design/esest_cfg_if.sv */
// esest_cfg_if: configuration write channel, register index and data
// no dependencies

interface esest_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

/* design/encoder_speed_estimator_core.sv */
// encoder_speed_estimator_core: speed estimate from successive encoder samples
// depends on esest_pkg and the esest_in_if, esest_out_if and esest_cfg_if channels
//
// One sample is taken at a time. A duplicate, first or zero-interval sample
// goes from acceptance through the output state into the output register,
// and no new sample is taken before it has left the output state. A sample
// that yields a speed runs nine arithmetic steps through one shared unit:
// each step is a 64x64 shift-add multiply between a load and a done state,
// and six of them go on into a 128/64 restoring divide. Its result is then
// presented through the output state, and the next sample can be taken once
// that state is left, which waits while the output is stalled. The sample
// port is not ready while a sample is in work; a finished result is held in
// the output register until it is taken. Configuration writes are always
// accepted and must only be made while the block is idle.

module encoder_speed_estimator_core #(
  parameter int SEQ_BITS = esest_pkg::SEQ_BITS
) (
  input logic        clk,
  input logic        rst,
  esest_in_if.sink   in_ch,
  esest_out_if.source out_ch,
  esest_cfg_if.sink  cfg
);

  // configuration
  logic [1:0]  polarity;
  logic [24:0] counts_per_rev;
  logic [31:0] gear_ratio_q16;
  logic [31:0] wheel_radius_mm_q16;

  // history
  logic [31:0]         prev_counts;
  logic [31:0]         prev_timestamp;
  logic [SEQ_BITS-1:0] prev_sequence;
  logic                have_history;

  // per-sample work registers
  esest_pkg::state_t  state, state_next;
  esest_pkg::status_t status;
  logic        neg;
  logic [31:0] mag;
  logic [31:0] dt;
  logic [3:0]  op;
  logic [63:0] res [esest_pkg::NUM_OPS];

  // shared arithmetic unit
  logic [127:0] acc;
  logic [127:0] a_sh;
  logic [63:0]  b_sh;
  logic [127:0] dvd;
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic         over;
  logic [6:0]   cnt;

  // operand selection
  logic [63:0] op_a, op_b, op_c, op_lim;
  logic        op_div;
  logic [63:0] cpr_eff, gear_eff, m64;

  // intake decode
  logic [47:0]         seq_ext;
  logic [SEQ_BITS-1:0] seq_in;
  logic [31:0]         dt_in;
  logic [31:0]         w_in;
  logic                in_fire;

  // control outputs
  logic in_ready;
  logic out_load;

  // divider step
  logic [64:0] rn;
  logic        ge;
  logic [64:0] rdiff;
  logic [63:0] sat_q;

  assign cfg.ready    = 1'b1;
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign seq_ext      = {32'd0, in_ch.sequence_req};
  assign seq_in       = seq_ext[SEQ_BITS-1:0];
  assign dt_in        = in_ch.sample_time_us - prev_timestamp;
  assign w_in         = in_ch.counts - prev_counts;

  assign cpr_eff  = (counts_per_rev == 25'd0) ? 64'd1 : {39'd0, counts_per_rev};
  assign gear_eff = (gear_ratio_q16 == 32'd0) ? 64'd1 : {32'd0, gear_ratio_q16};
  assign m64      = {32'd0, mag};

  always_comb begin
    op_a   = m64;
    op_b   = 64'd0;
    op_c   = 64'd1;
    op_lim = esest_pkg::SAT_NONE;
    op_div = 1'b0;
    unique case (op)
      esest_pkg::OP_CPS: begin
        op_b = esest_pkg::US_PER_S;  op_c = {32'd0, dt};  op_div = 1'b1;
      end
      esest_pkg::OP_ANGM: begin
        op_b = esest_pkg::TWO_PI_Q16; op_c = cpr_eff; op_div = 1'b1;
        op_lim = esest_pkg::SAT_ANGLE;
      end
      esest_pkg::OP_ANGW: begin
        op_a = res[esest_pkg::OP_ANGM]; op_b = esest_pkg::Q16_ONE; op_c = gear_eff;
        op_div = 1'b1; op_lim = esest_pkg::SAT_ANGLE;
      end
      esest_pkg::OP_X: begin
        op_b = esest_pkg::US_PER_MIN;
      end
      esest_pkg::OP_Y: begin
        op_a = {32'd0, dt}; op_b = cpr_eff;
      end
      esest_pkg::OP_RPMM: begin
        op_a = res[esest_pkg::OP_X]; op_b = esest_pkg::Q16_ONE; op_c = res[esest_pkg::OP_Y];
        op_div = 1'b1; op_lim = esest_pkg::SAT_WIDE;
      end
      esest_pkg::OP_RPMW: begin
        op_a = res[esest_pkg::OP_RPMM]; op_b = esest_pkg::Q16_ONE; op_c = gear_eff;
        op_div = 1'b1; op_lim = esest_pkg::SAT_WIDE;
      end
      esest_pkg::OP_Z: begin
        op_a = esest_pkg::TWO_PI_Q16; op_b = {32'd0, wheel_radius_mm_q16};
      end
      esest_pkg::OP_MPS: begin
        op_a = res[esest_pkg::OP_RPMW]; op_b = res[esest_pkg::OP_Z];
        op_c = esest_pkg::MPS_DIV; op_div = 1'b1; op_lim = esest_pkg::SAT_WIDE;
      end
      default: begin
        op_a = m64;
      end
    endcase
  end

  // one restoring division step, overflow past the low 64 quotient bits saturates
  assign rn    = {rem, dvd[127]};
  assign ge    = rn >= {1'b0, op_c};
  assign rdiff = rn - {1'b0, op_c};
  assign sat_q = (over || quo > op_lim) ? op_lim : quo;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      esest_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (seq_in != prev_sequence && have_history && dt_in != 32'd0)
            state_next = esest_pkg::ST_LOAD;
          else
            state_next = esest_pkg::ST_OUT;
        end
      end
      esest_pkg::ST_LOAD:  state_next = esest_pkg::ST_MUL;
      esest_pkg::ST_MUL:   if (cnt[5:0] == 6'd63) state_next = esest_pkg::ST_MDONE;
      esest_pkg::ST_MDONE: begin
        if (op_div)
          state_next = esest_pkg::ST_DIV;
        else if (op == esest_pkg::OP_MPS)
          state_next = esest_pkg::ST_OUT;
        else
          state_next = esest_pkg::ST_LOAD;
      end
      esest_pkg::ST_DIV:   if (cnt == 7'd127) state_next = esest_pkg::ST_DDONE;
      esest_pkg::ST_DDONE: begin
        if (op == esest_pkg::OP_MPS)
          state_next = esest_pkg::ST_OUT;
        else
          state_next = esest_pkg::ST_LOAD;
      end
      esest_pkg::ST_OUT:   if (out_load) state_next = esest_pkg::ST_IDLE;
      default:             state_next = esest_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      esest_pkg::ST_IDLE: in_ready = 1'b1;
      esest_pkg::ST_OUT:  out_load = !out_ch.valid || out_ch.ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esest_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      polarity            <= esest_pkg::POLARITY_RESET;
      counts_per_rev      <= esest_pkg::CPR_RESET;
      gear_ratio_q16      <= esest_pkg::GEAR_RESET;
      wheel_radius_mm_q16 <= esest_pkg::RADIUS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        esest_pkg::REG_POLARITY: polarity            <= cfg.data[1:0];
        esest_pkg::REG_CPR:      counts_per_rev      <= cfg.data[24:0];
        esest_pkg::REG_GEAR:     gear_ratio_q16      <= cfg.data;
        esest_pkg::REG_RADIUS:   wheel_radius_mm_q16 <= cfg.data;
        default:                 polarity            <= polarity;
      endcase
    end
  end

  // history and sample intake
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_counts    <= '0;
      prev_timestamp <= '0;
      prev_sequence  <= '0;
      have_history   <= 1'b0;
    end else if (in_fire && seq_in != prev_sequence) begin
      prev_counts    <= in_ch.counts;
      prev_timestamp <= in_ch.sample_time_us;
      prev_sequence  <= seq_in;
      have_history   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dt <= dt_in;
      op <= esest_pkg::OP_CPS;
      if (seq_in == prev_sequence)
        status <= esest_pkg::STATUS_DUP;
      else if (!have_history)
        status <= esest_pkg::STATUS_FIRST;
      else if (dt_in == 32'd0)
        status <= esest_pkg::STATUS_ZERO;
      else
        status <= esest_pkg::STATUS_VALID;
      // shortest wrapped difference, then polarity
      if (polarity == 2'd0) begin
        mag <= 32'd0;
        neg <= 1'b0;
      end else begin
        mag <= w_in[31] ? (32'd0 - w_in) : w_in;
        neg <= w_in[31] ^ polarity[1];
      end
    end
    unique case (state)
      esest_pkg::ST_LOAD: begin
        acc  <= '0;
        a_sh <= {64'd0, op_a};
        b_sh <= op_b;
        cnt  <= '0;
      end
      esest_pkg::ST_MUL: begin
        if (b_sh[0])
          acc <= acc + a_sh;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 7'd1;
      end
      esest_pkg::ST_MDONE: begin
        dvd  <= acc;
        rem  <= '0;
        quo  <= '0;
        over <= 1'b0;
        cnt  <= '0;
        if (!op_div) begin
          res[op] <= acc[63:0];
          op      <= op + 4'd1;
        end
      end
      esest_pkg::ST_DIV: begin
        dvd  <= dvd << 1;
        rem  <= ge ? rdiff[63:0] : rn[63:0];
        quo  <= {quo[62:0], ge};
        over <= over || (ge && !cnt[6]);
        cnt  <= cnt + 7'd1;
      end
      esest_pkg::ST_DDONE: begin
        res[op] <= sat_q;
        op      <= op + 4'd1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.status <= status;
      if (status == esest_pkg::STATUS_VALID) begin
        out_ch.count_delta <= neg ? (33'd0 - {1'b0, mag}) : {1'b0, mag};
        out_ch.interval_us <= dt;
        out_ch.count_rate  <= neg ? (52'd0 - res[esest_pkg::OP_CPS][51:0])
                                  : res[esest_pkg::OP_CPS][51:0];
        out_ch.motor_angle_delta_q16 <= neg ? (54'd0 - res[esest_pkg::OP_ANGM][53:0])
                                            : res[esest_pkg::OP_ANGM][53:0];
        out_ch.wheel_angle_delta_q16 <= neg ? (54'd0 - res[esest_pkg::OP_ANGW][53:0])
                                            : res[esest_pkg::OP_ANGW][53:0];
        out_ch.motor_rpm_q16 <= neg ? (64'd0 - res[esest_pkg::OP_RPMM])
                                    : res[esest_pkg::OP_RPMM];
        out_ch.wheel_rpm_q16 <= neg ? (64'd0 - res[esest_pkg::OP_RPMW])
                                    : res[esest_pkg::OP_RPMW];
        out_ch.wheel_mps_q16 <= neg ? (64'd0 - res[esest_pkg::OP_MPS])
                                    : res[esest_pkg::OP_MPS];
        out_ch.rate_ok       <= 1'b1;
      end else begin
        out_ch.count_delta           <= '0;
        out_ch.interval_us           <= '0;
        out_ch.count_rate            <= '0;
        out_ch.motor_angle_delta_q16 <= '0;
        out_ch.wheel_angle_delta_q16 <= '0;
        out_ch.motor_rpm_q16         <= '0;
        out_ch.wheel_rpm_q16         <= '0;
        out_ch.wheel_mps_q16         <= '0;
        out_ch.rate_ok               <= 1'b0;
      end
    end
  end

endmodule

/* verif/esest_checker.sv */
// esest_checker: watches sample, config and estimate channels, predicts each estimate
// depends on esest_pkg and the esest_in_if, esest_out_if and esest_cfg_if interfaces
`timescale 1ns / 100ps

module esest_checker (
  input  logic          clk,
  input  logic          rst,
  esest_in_if.monitor   in_mon,
  esest_out_if.monitor  out_mon,
  esest_cfg_if.monitor  cfg_mon,
  output int            fail_count,
  output int            pending_count
);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [32:0] count_delta;
    logic [31:0]        interval_us;
    logic signed [51:0] count_rate;
    logic signed [53:0] motor_angle;
    logic signed [53:0] wheel_angle;
    logic signed [63:0] motor_rpm;
    logic signed [63:0] wheel_rpm;
    logic signed [63:0] wheel_mps;
    logic               rate_ok;
  } estimate_t;

  estimate_t   estimate_q[$];
  logic [1:0]  polarity_r;
  logic [24:0] cpr_r;
  logic [31:0] gear_r;
  logic [31:0] radius_r;
  logic [31:0] hist_counts;
  logic [31:0] last_ts;
  logic [esest_pkg::SEQ_BITS-1:0] last_seq;
  logic        primed;

  assign pending_count = estimate_q.size();

  // floor(a*b/c) with 128-bit product, clamped to limit
  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] c, logic [63:0] limit);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, a} * {64'd0, b};
    quo  = prod / {64'd0, c};
    if (quo > {64'd0, limit}) return limit;
    return quo[63:0];
  endfunction

  function automatic estimate_t predict_estimate(logic [31:0] cnt, logic [31:0] ts,
                                                 logic [esest_pkg::SEQ_BITS-1:0] seq);
    estimate_t e;
    logic [31:0] dt, w;
    logic [63:0] mag, cpr, gear, cps, angm, angw, rpmm, rpmw, mps;
    logic neg;
    e = '0;
    if (seq == last_seq) return e;
    if (!primed) begin
      e.status = esest_pkg::STATUS_FIRST;
    end else begin
      dt = ts - last_ts;
      if (dt == 0) begin
        e.status = esest_pkg::STATUS_ZERO;
      end else begin
        w = cnt - hist_counts;
        neg = w[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, w}) : {32'd0, w};
        if (polarity_r == 2'd0) mag = 0;
        else if (polarity_r[1]) neg = !neg;
        cpr  = (cpr_r == 0) ? 64'd1 : {39'd0, cpr_r};
        gear = (gear_r == 0) ? 64'd1 : {32'd0, gear_r};
        cps  = (mag * esest_pkg::US_PER_S) / {32'd0, dt};
        angm = scaled_quotient(mag, esest_pkg::TWO_PI_Q16, cpr, esest_pkg::SAT_ANGLE);
        angw = scaled_quotient(angm, esest_pkg::Q16_ONE, gear, esest_pkg::SAT_ANGLE);
        rpmm = scaled_quotient(mag * esest_pkg::US_PER_MIN, esest_pkg::Q16_ONE,
                               {32'd0, dt} * cpr, esest_pkg::SAT_WIDE);
        rpmw = scaled_quotient(rpmm, esest_pkg::Q16_ONE, gear, esest_pkg::SAT_WIDE);
        mps  = scaled_quotient(rpmw, esest_pkg::TWO_PI_Q16 * {32'd0, radius_r},
                               esest_pkg::MPS_DIV, esest_pkg::SAT_WIDE);
        if (neg) begin
          mag = -mag; cps = -cps; angm = -angm; angw = -angw;
          rpmm = -rpmm; rpmw = -rpmw; mps = -mps;
        end
        e.status = esest_pkg::STATUS_VALID;
        e.count_delta = mag[32:0];
        e.interval_us = dt;
        e.count_rate = cps[51:0];
        e.motor_angle = angm[53:0];
        e.wheel_angle = angw[53:0];
        e.motor_rpm = rpmm;
        e.wheel_rpm = rpmw;
        e.wheel_mps = mps;
        e.rate_ok = 1'b1;
      end
    end
    return e;
  endfunction

  always @(posedge clk) begin
    estimate_t exp_e, got;
    if (rst) begin
      polarity_r <= esest_pkg::POLARITY_RESET;
      cpr_r <= esest_pkg::CPR_RESET;
      gear_r <= esest_pkg::GEAR_RESET;
      radius_r <= esest_pkg::RADIUS_RESET;
      hist_counts <= '0;
      last_ts <= '0;
      last_seq <= '0;
      primed <= 1'b0;
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          esest_pkg::REG_POLARITY: polarity_r <= cfg_mon.data[1:0];
          esest_pkg::REG_CPR:      cpr_r <= cfg_mon.data[24:0];
          esest_pkg::REG_GEAR:     gear_r <= cfg_mon.data;
          esest_pkg::REG_RADIUS:   radius_r <= cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        estimate_q.push_back(predict_estimate(in_mon.counts, in_mon.sample_time_us,
                                              in_mon.sequence_req[esest_pkg::SEQ_BITS-1:0]));
        if (in_mon.sequence_req[esest_pkg::SEQ_BITS-1:0] != last_seq) begin
          hist_counts <= in_mon.counts;
          last_ts <= in_mon.sample_time_us;
          last_seq <= in_mon.sequence_req[esest_pkg::SEQ_BITS-1:0];
          primed <= 1'b1;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.status, out_mon.count_delta, out_mon.interval_us,
                out_mon.count_rate, out_mon.motor_angle_delta_q16,
                out_mon.wheel_angle_delta_q16, out_mon.motor_rpm_q16,
                out_mon.wheel_rpm_q16, out_mon.wheel_mps_q16, out_mon.rate_ok};
        if (estimate_q.size() == 0) begin
          $display("%0t: unexpected estimate, exp none got %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_e = estimate_q.pop_front();
          if (got != exp_e) begin
            $display("%0t: estimate mismatch", $time);
            $display("  status exp %0d got %0d", exp_e.status, got.status);
            $display("  count_delta exp %0d got %0d", exp_e.count_delta, got.count_delta);
            $display("  interval exp %0d got %0d", exp_e.interval_us, got.interval_us);
            $display("  count_rate exp %0d got %0d", exp_e.count_rate, got.count_rate);
            $display("  motor_angle exp %0d got %0d", exp_e.motor_angle, got.motor_angle);
            $display("  wheel_angle exp %0d got %0d", exp_e.wheel_angle, got.wheel_angle);
            $display("  motor_rpm exp %0d got %0d", exp_e.motor_rpm, got.motor_rpm);
            $display("  wheel_rpm exp %0d got %0d", exp_e.wheel_rpm, got.wheel_rpm);
            $display("  wheel_mps exp %0d got %0d", exp_e.wheel_mps, got.wheel_mps);
            $display("  rate_ok exp %0d got %0d", exp_e.rate_ok, got.rate_ok);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* verif/encoder_speed_estimator_core_tb.sv */
// encoder_speed_estimator_core_tb: drives samples and config writes into the core
// depends on esest_pkg, the channel interfaces, esest_checker and the core
`timescale 1ns / 100ps

module encoder_speed_estimator_core_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   idle_cycles = 0;
  int   burst_left = 0;
  logic [31:0] cur_counts = 0;
  logic [31:0] cur_ts = 0;
  logic [15:0] cur_seq = 0;

  esest_in_if  in_ch();
  esest_out_if out_ch();
  esest_cfg_if cfg();

  encoder_speed_estimator_core DUT (.clk(clk), .rst(rst), .in_ch(in_ch),
                                    .out_ch(out_ch), .cfg(cfg));

  esest_checker u_checker (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                           .cfg_mon(cfg), .fail_count(fail_count),
                           .pending_count(pending_count));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random, with stretches in which it never stalls
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[11:9] == 3'd0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] cnt, logic [31:0] ts, logic [15:0] seq);
    in_ch.valid <= 1'b1;
    in_ch.counts <= cnt;
    in_ch.sample_time_us <= ts;
    in_ch.sequence_req <= seq;
    do @(posedge clk); while (!in_ch.ready);
    cur_counts = cnt;
    cur_ts = ts;
    if (seq != 0) cur_seq = seq;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(0, 6);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    case ($urandom_range(0, 3))
      0: write_reg(esest_pkg::REG_POLARITY, 32'd1);
      1: write_reg(esest_pkg::REG_POLARITY, 32'h3);
      2: write_reg(esest_pkg::REG_POLARITY, 32'd0);
      default: write_reg(esest_pkg::REG_POLARITY, 32'd2);
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(esest_pkg::REG_CPR, 32'd1);
      1: write_reg(esest_pkg::REG_CPR, 32'd16777216);
      2: write_reg(esest_pkg::REG_CPR, 32'd0);
      default: write_reg(esest_pkg::REG_CPR, $urandom & 32'h01FF_FFFF);
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(esest_pkg::REG_GEAR, 32'd1);
      1: write_reg(esest_pkg::REG_GEAR, 32'hFFFF_FFFF);
      2: write_reg(esest_pkg::REG_GEAR, 32'd0);
      default: write_reg(esest_pkg::REG_GEAR, $urandom);
    endcase
    case ($urandom_range(0, 2))
      0: write_reg(esest_pkg::REG_RADIUS, 32'd0);
      1: write_reg(esest_pkg::REG_RADIUS, 32'hFFFF_FFFF);
      default: write_reg(esest_pkg::REG_RADIUS, $urandom);
    endcase
  endtask

  // mostly plausible motion with fresh sequence numbers, some noise
  task automatic random_sample();
    logic [31:0] cnt, ts;
    logic [15:0] seq;
    int kind;
    kind = $urandom_range(0, 19);
    cnt = cur_counts + $urandom_range(0, 4000) - 2000;
    ts = cur_ts + $urandom_range(1, 5000);
    seq = cur_seq + 1;
    if (kind == 0) seq = cur_seq;
    else if (kind == 1) ts = cur_ts;
    else if (kind == 2) cnt = $urandom;
    else if (kind == 3) ts = $urandom;
    else if (kind == 4) seq = $urandom;
    else if (kind == 5) cnt = cur_counts + 32'h8000_0000;
    else if (kind == 6) cnt = cur_counts + 32'h7FFF_FFFF;
    else if (kind == 7) ts = cur_ts + 1;
    send_sample(cnt, ts, seq);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.counts = '0;
    in_ch.sample_time_us = '0;
    in_ch.sequence_req = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    out_ch.ready = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // duplicate of reset sequence, first sample, zero interval, duplicate, then speeds
    send_sample(32'd100, 32'd10, 16'd0);
    send_sample(32'd100, 32'd10, 16'd1);
    send_sample(32'd200, 32'd10, 16'd2);
    send_sample(32'd200, 32'd20, 16'd2);
    send_sample(32'h7FFF_FFFF, 32'd30, 16'd3);
    send_sample(32'h8000_0000, 32'd31, 16'd4);
    send_sample(32'h0000_0000, 32'd32, 16'd5);
    send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_sample(32'hFFFF_FFFF, 32'd5, 16'd7);
    drain();
    write_reg(esest_pkg::REG_POLARITY, 32'h3);
    write_reg(esest_pkg::REG_CPR, 32'd1);
    write_reg(esest_pkg::REG_GEAR, 32'd1);
    write_reg(esest_pkg::REG_RADIUS, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 32'd6, 16'd8);
    send_sample(32'h0000_0000, 32'd7, 16'd9);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd10);
    drain();
    write_reg(esest_pkg::REG_POLARITY, 32'd2);
    write_reg(esest_pkg::REG_CPR, 32'd0);
    write_reg(esest_pkg::REG_GEAR, 32'd0);
    write_reg(esest_pkg::REG_RADIUS, 32'd0);
    send_sample(32'h1234_5678, 32'd100, 16'd11);
    send_sample(32'h0000_0001, 32'd101, 16'd12);
    drain();
    write_reg(esest_pkg::REG_POLARITY, 32'd0);
    write_reg(esest_pkg::REG_CPR, 32'd16777216);
    write_reg(esest_pkg::REG_GEAR, 32'hFFFF_FFFF);
    send_sample(32'h0000_5000, 32'd200, 16'd13);
    send_sample(32'h0000_9000, 32'd900, 16'd14);
    drain();

    for (int phase = 0; phase < 16; phase++) begin
      random_config();
      for (int n = 0; n < 95; n++) random_sample();
      drain();
    end

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
